FILE: hw/rtl/crc32_msb_direct_stream_unit_defines.svh
// ----------------------------------------------------------------------------
// CRC-32 stream unit: assertion macros
// Shared property macros for the checker. They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CRC32_MSB_DIRECT_STREAM_UNIT_DEFINES_SVH
`define CRC32_MSB_DIRECT_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication with a delayed consequent, disabled during reset
`define CRC_ASSERT_TWO(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/crc32ms_pkg.sv
// ----------------------------------------------------------------------------
// crc32ms_pkg
// Constants, control types and the byte-wide shift-xor term of the CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc32ms_pkg;

	localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_TOP    = 32'h8000_0000;
	localparam logic [2:0]  LOAD_BYTES = 3'd4;

	// Control from the input stage to the update logic
	typedef struct packed {
		logic fire;   // stage-1 byte is consumed this cycle
		logic last;   // that byte closes the message
	} step_ctl_t;

	// Top byte run through eight shift-xor steps with the polynomial
	function automatic logic [31:0] crc_top_term(input logic [7:0] top);
		logic [31:0] v;
		v = {top, 24'h00_0000};
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_TOP) != 32'h0) begin
				v = (v << 1) ^ CRC_POLY;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/crc32_msb_direct_stream_unit.sv
// A final byte passes the input register, then the result register, before out_valid rises.
// Throughput: one byte per cycle unless a final byte waits (below); the remainder update is one
// 8-step xor network fed back through the division register on every consumed byte.
// A final byte waits in the input register only while an earlier checksum is unclaimed.
// Reset (arst_n low) clears the remainder, the byte count and all valid flags.
// ----------------------------------------------------------------------------
// crc32_msb_direct_stream_unit
// Streaming MSB-first CRC-32 (poly 04C11DB7) by direct division, one byte per
// transaction, one checksum per message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32_msb_direct_stream_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] crc_value
);
	import crc32ms_pkg::*;

	step_ctl_t   ctl;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        res_valid;
	logic [31:0] res_value;

	// Input register
	crc32ms_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_free  (out_free),
		.ctl       (ctl),
		.byte_s1   (byte_s1)
	);

	// Remainder update
	crc32ms_update u_upd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// Result register
	crc32ms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_value (res_value),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.crc_value (crc_value)
	);

endmodule

FILE: hw/rtl/crc32ms_in_stage.sv
// ----------------------------------------------------------------------------
// crc32ms_in_stage
// Input register; releases its byte unless a final byte meets a full output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32ms_in_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic                   out_free,
	output crc32ms_pkg::step_ctl_t ctl,
	output logic [7:0]             byte_s1
);
	import crc32ms_pkg::*;

	logic valid_s1;
	logic last_s1;
	logic fire;

	// A non-final byte never produces a result, so it never waits
	assign fire     = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || fire;
	assign ctl      = '{fire: fire, last: last_s1};

	// Stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage-1 payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

endmodule

FILE: hw/rtl/crc32ms_update.sv
// ----------------------------------------------------------------------------
// crc32ms_update
// Division register, load counter and the per-byte remainder update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32ms_update (
	input  logic                   clk,
	input  logic                   arst_n,
	input  crc32ms_pkg::step_ctl_t ctl,
	input  logic [7:0]             byte_s1,
	output logic                   res_valid,
	output logic [31:0]            res_value
);
	import crc32ms_pkg::*;

	logic [31:0] remainder_q;
	logic [2:0]  count_q;
	logic [31:0] load_v;
	logic [31:0] crc_v;
	logic [31:0] short_v;
	logic [2:0]  count_inc;
	logic        loading;
	logic [31:0] remainder_d;
	logic [2:0]  count_d;

	// Datapath: shift-in, polynomial term and left-aligned short result
	always_comb begin
		load_v    = {remainder_q[23:0], byte_s1};
		crc_v     = crc_top_term(remainder_q[31:24]) ^ load_v;
		loading   = (count_q != LOAD_BYTES);
		count_inc = 3'(count_q + 3'd1);
		case (count_q)
			3'd0:    short_v = {load_v[7:0], 24'h00_0000};
			3'd1:    short_v = {load_v[15:0], 16'h0000};
			3'd2:    short_v = {load_v[23:0], 8'h00};
			default: short_v = load_v;
		endcase
	end

	assign res_valid = ctl.fire && ctl.last;
	assign res_value = loading ? short_v : ~crc_v;

	// Next state; a final byte returns everything to zero
	always_comb begin
		remainder_d = remainder_q;
		count_d     = count_q;
		if (ctl.last) begin
			remainder_d = 32'h0;
			count_d     = 3'd0;
		end else if (loading) begin
			count_d     = count_inc;
			remainder_d = (count_inc == LOAD_BYTES) ? ~load_v : load_v;
		end else begin
			remainder_d = crc_v;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= 32'h0;
			count_q     <= 3'd0;
		end else if (ctl.fire) begin
			remainder_q <= remainder_d;
			count_q     <= count_d;
		end
	end

endmodule

FILE: hw/rtl/crc32ms_out_reg.sv
// ----------------------------------------------------------------------------
// crc32ms_out_reg
// Result register holding one checksum until the transaction completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32ms_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  logic [31:0] res_value,
	output logic        out_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] crc_value
);
	import crc32ms_pkg::*;

	logic valid_q;
	logic [31:0] crc_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign crc_value = crc_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	// Checksum payload
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			crc_q <= res_value;
		end
	end

endmodule

FILE: hw/rtl/crc32ms_checker.sv
// ----------------------------------------------------------------------------
// crc32ms_checker
// Port-level checks on the CRC stream unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc32_msb_direct_stream_unit_defines.svh"

module crc32ms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] crc_value
);

	logic out_stall;
	logic last_tx;

	assign out_stall = out_valid && !out_ready;
	assign last_tx   = in_valid && in_ready && last_byte;

	// Stalled result transaction stays up and unchanged
	`CRC_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")
	`CRC_ASSERT_NEXT(a_out_stable, out_stall, $stable(crc_value), "result changed in stall")

	// Every final byte is followed by a checksum on out_valid
	`CRC_ASSERT_TWO(a_last_gives_result, last_tx, out_valid, "no checksum after final byte")

	// A checksum appears only after a final byte was taken
	`CRC_ASSERT_SAME(a_result_has_cause, $rose(out_valid), $past(last_tx, 2), "orphan checksum")

endmodule

bind crc32_msb_direct_stream_unit crc32ms_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.crc_value (crc_value)
);

FILE: verif/tb_crc32_msb_direct_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc32_msb_direct_stream_unit
// Self-checking bench for the streaming MSB-first CRC-32 unit. Messages of
// mixed lengths are queued and sent one byte per transaction. Each accepted
// byte goes through a bit-serial division model kept in the bench. Every
// checksum the unit returns is compared with the oldest predicted one. Three
// handshake profiles are used: sender-heavy idling, receiver-heavy stalling,
// and none.
// ----------------------------------------------------------------------------

module tb_crc32_msb_direct_stream_unit;

	import crc32ms_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	localparam int PHASE_ITEMS = 533;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] crc_value;

	// bytes waiting to be sent, checksums waiting to come back
	msg_byte_t   byte_q[$];
	logic [31:0] crc_expected_q[$];

	// division model state
	logic [31:0] crc_rem = 32'h0;
	logic [2:0]  crc_count = 3'd0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int err_count = 0;
	int msgs_checked = 0;
	int bytes_sent = 0;
	int longest_msg = 0;
	int phase_items = 0;

	crc32_msb_direct_stream_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.crc_value (crc_value)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the division model by one accepted byte; a final byte queues
	// the checksum and clears the model for the next message.
	task automatic crc_predict(input logic [7:0] din, input logic fin);
		logic [31:0] acc;
		logic        msb;
		int          n;
		if (crc_count < LOAD_BYTES) begin
			// loading phase: bytes shift in big-endian
			acc = {crc_rem[23:0], din};
			n = crc_count + 1;
			if (fin) begin
				// short message: left-aligned, zero-padded
				crc_expected_q = {crc_expected_q, acc << (8 * (4 - n))};
				crc_rem = 32'h0;
				crc_count = 3'd0;
			end else begin
				crc_count = crc_count + 3'd1;
				crc_rem = (crc_count == LOAD_BYTES) ? ~acc : acc;
			end
		end else begin
			// one bit at a time: shift data in at the bottom, reduce on carry-out
			acc = crc_rem;
			for (int i = 7; i >= 0; i--) begin
				msb = acc[31];
				acc = {acc[30:0], din[i]};
				if (msb) begin
					acc = acc ^ CRC_POLY;
				end
			end
			if (fin) begin
				crc_expected_q = {crc_expected_q, ~acc};
				crc_rem = 32'h0;
				crc_count = 3'd0;
			end else begin
				crc_rem = acc;
			end
		end
	endtask

	// Queue one message of len bytes; pat picks the byte content
	task automatic add_message(input int len, input int pat);
		msg_byte_t mb;
		for (int i = 0; i < len; i++) begin
			case (pat)
				1: mb.data = 8'h00;
				2: mb.data = 8'hFF;
				3: mb.data = i[0] ? 8'h55 : 8'hAA;
				4: mb.data = 8'h80;
				default: mb.data = 8'($urandom_range(255));
			endcase
			mb.last = (i == len - 1);
			byte_q = {byte_q, mb};
		end
		if (len > longest_msg) begin
			longest_msg = len;
		end
		phase_items += len;
	endtask

	// Hold off until the queue is sent and every checksum is back
	task automatic wait_drained();
		while (byte_q.size() != 0 || in_valid || crc_expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Driver: present queued bytes, idle at random between transactions
	always @(posedge clk or negedge arst_n) begin : drive_proc
		msg_byte_t mb;
		logic      hold;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			hold = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				crc_predict(data_byte, last_byte);
				bytes_sent++;
			end
			if (!hold) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					mb = byte_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= mb.data;
					last_byte <= mb.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted checksum, stall the output at random
	always @(posedge clk or negedge arst_n) begin : mon_proc
		logic [31:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (crc_expected_q.size() == 0) begin
					if (err_count < 10) begin
						$display("ERROR %0t: unexpected checksum %08h", $realtime, crc_value);
					end
					err_count++;
				end else begin
					want = crc_expected_q.pop_front();
					msgs_checked++;
					if (crc_value !== want) begin
						if (err_count < 10) begin
							$display("ERROR %0t: crc_value expected %08h got %08h",
								$realtime, want, crc_value);
						end
						err_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus: directed messages, then random ones over three profiles
	initial begin : stim_proc
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_items = 0;
			if (ph == 0) begin
				// extremes: one to five bytes, all-zero, all-one, alternating and random content
				add_message(1, 1);
				add_message(1, 2);
				add_message(2, 2);
				add_message(3, 0);
				add_message(4, 1);
				add_message(4, 2);
				add_message(5, 2);
				add_message(5, 3);
			end
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 40) begin
					add_message($urandom_range(4, 1), 0);
				end else if (r < 85) begin
					add_message($urandom_range(16, 5), ($urandom_range(9) == 0) ?
						$urandom_range(4, 1) : 0);
				end else begin
					add_message($urandom_range(64, 17), 0);
				end
			end
			// sender pauses until every checksum is back
			wait_drained();
		end
		repeat (8) @(posedge clk);
		$display("Checked %0d checksums over %0d bytes, messages of 1 to %0d bytes,",
			msgs_checked, bytes_sent, longest_msg);
		$display("under sender idling, receiver stalling and full-rate traffic.");
		if (err_count == 0 && crc_expected_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout with %0d checksums outstanding", crc_expected_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/crc32ms_pkg.sv
hw/rtl/crc32ms_in_stage.sv
hw/rtl/crc32ms_update.sv
hw/rtl/crc32ms_out_reg.sv
hw/rtl/crc32_msb_direct_stream_unit.sv
hw/rtl/crc32ms_checker.sv
verif/tb_crc32_msb_direct_stream_unit.sv
